// ===== src/vna_pkg.sv =====
// Shared types and constants for the vertex normal accumulator.
package vna_pkg;

  localparam int MAX_VERTICES_DEF  = 1024;
  localparam int POSITION_BITS_DEF = 20;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 20;
  localparam int CNT_W  = 11;
  localparam int NRM_W  = 16;
  localparam int ACC_W  = 48;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  localparam int MAG_W  = 30;
  localparam int RAD_W  = 2 * MAG_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int QUO_W  = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRI   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TRI,
    OP_QUERY,
    OP_QZERO
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        vertex_index;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        queried_index;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    zero_normal;
  } result_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
  } entry_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic done;
    logic idle;
  } norm_stat_t;

endpackage

// ===== src/vna_front.sv =====
// Front end: accepts commands, classifies them and queues work for the back end.
module vna_front #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  vna_pkg::item_t             item,
  input  logic                       cfg_we,
  input  logic [vna_pkg::CNT_W-1:0]  cfg_wdata,
  input  vna_pkg::back_stat_t        stat,
  output logic                       head_valid,
  output vna_pkg::entry_t            head
);

  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

  logic [vna_pkg::CNT_W-1:0] vertex_count;
  vna_pkg::entry_t           q [vna_pkg::QDEPTH];
  logic [vna_pkg::QPW-1:0]   wr_ptr;
  logic [vna_pkg::QPW-1:0]   rd_ptr;
  logic [vna_pkg::QPW:0]     count;
  logic [vna_pkg::QPW:0]     count_next;
  vna_pkg::entry_t           ent;
  logic                      keep;
  logic                      accept;
  logic                      push;
  logic                      pop;
  logic                      in_a, in_b, in_c;
  logic                      use_a, use_b, use_c;

  always_comb begin
    in_a  = 17'(item.vertex_index) < MAXV;
    in_b  = 17'(item.corner_b) < MAXV;
    in_c  = 17'(item.corner_c) < MAXV;
    use_a = vna_pkg::CNT_W'(item.vertex_index) < vertex_count;
    use_b = vna_pkg::CNT_W'(item.corner_b) < vertex_count;
    use_c = vna_pkg::CNT_W'(item.corner_c) < vertex_count;
    ent.op = vna_pkg::OP_LOAD;
    ent.ia = item.vertex_index;
    ent.ib = item.corner_b;
    ent.ic = item.corner_c;
    ent.px = item.pos_x;
    ent.py = item.pos_y;
    ent.pz = item.pos_z;
    keep   = 1'b0;
    unique case (item.cmd)
      vna_pkg::CMD_LOAD: begin
        keep = in_a;
      end
      vna_pkg::CMD_TRI: begin
        ent.op = vna_pkg::OP_TRI;
        keep   = in_a & in_b & in_c & use_a & use_b & use_c;
      end
      vna_pkg::CMD_QUERY: begin
        ent.op = in_a ? vna_pkg::OP_QUERY : vna_pkg::OP_QZERO;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy       = stat.clearing | (count == (vna_pkg::QPW + 1)'(vna_pkg::QDEPTH));
  assign accept     = start & ~busy;
  assign push       = accept & keep;
  assign pop        = stat.pop;
  assign head_valid = count != '0;
  assign head       = q[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= ent;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (vna_pkg::QPW + 1)'(vna_pkg::QDEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

// ===== src/vna_norm.sv =====
// Normalizer: scales an accumulated normal to unit length with iterative root and divide.
module vna_norm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [3*vna_pkg::ACC_W-1:0]       acc,
  output vna_pkg::norm_stat_t               nstat,
  output logic signed [vna_pkg::NRM_W-1:0]  nx,
  output logic signed [vna_pkg::NRM_W-1:0]  ny,
  output logic signed [vna_pkg::NRM_W-1:0]  nz,
  output logic                              nzero
);

  localparam int AW  = vna_pkg::ACC_W;
  localparam int MW  = vna_pkg::MAG_W;
  localparam int RW  = vna_pkg::RAD_W;
  localparam int LW  = vna_pkg::ROOT_W;
  localparam int QW  = vna_pkg::QUO_W;
  localparam int NW  = vna_pkg::NRM_W;

  typedef enum logic [9:0] {
    N_IDLE  = 10'b0000000001,
    N_MAX   = 10'b0000000010,
    N_SHIFT = 10'b0000000100,
    N_SQ    = 10'b0000001000,
    N_SUM   = 10'b0000010000,
    N_SQRT  = 10'b0000100000,
    N_DINIT = 10'b0001000000,
    N_DIV   = 10'b0010000000,
    N_STORE = 10'b0100000000,
    N_OUT   = 10'b1000000000
  } nstate_t;

  nstate_t              state;
  logic [2:0]           sgn;
  logic [AW-1:0]        m0, m1, m2, mx;
  logic [2*MW-1:0]      sq0, sq1, sq2;
  logic [RW-1:0]        rad;
  logic [LW+1:0]        rem;
  logic [LW-1:0]        root;
  logic [4:0]           scnt;
  logic [$clog2(QW)-1:0] dcnt;
  logic [1:0]           k;
  logic [LW:0]          drem;
  logic [QW-1:0]        dlow;
  logic [QW-1:0]        quo;
  logic [LW+3:0]        rem_sh;
  logic [LW+3:0]        trial;
  logic [LW+1:0]        dsh;
  logic [LW+1:0]        dv;
  logic [MW-1:0]        msel;
  logic                 ssel;
  logic [QW-2:0]        qsat;
  logic [NW-1:0]        nval;
  logic signed [AW-1:0] ax, ay, az;

  assign ax = acc[AW-1:0];
  assign ay = acc[2*AW-1:AW];
  assign az = acc[3*AW-1:2*AW];

  assign nstat.done = state == N_OUT;
  assign nstat.idle = state == N_IDLE;

  always_comb begin
    rem_sh = {rem, rad[RW-1:RW-2]};
    trial  = (LW + 4)'({root, 2'b01});
    dsh    = {drem, dlow[QW-1]};
    dv     = (LW + 2)'({root, 1'b0});
    unique case (k)
      2'd0:    begin msel = m0[MW-1:0]; ssel = sgn[0]; end
      2'd1:    begin msel = m1[MW-1:0]; ssel = sgn[1]; end
      default: begin msel = m2[MW-1:0]; ssel = sgn[2]; end
    endcase
    qsat = quo[QW-1] ? '1 : quo[QW-2:0];
    nval = ssel ? -{1'b0, qsat} : {1'b0, qsat};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (go) begin
            state <= (acc == '0) ? N_OUT : N_MAX;
          end
        end
        N_MAX: begin
          state <= N_SHIFT;
        end
        N_SHIFT: begin
          if (mx[AW-1:MW] == '0 && mx[MW-1]) begin
            state <= N_SQ;
          end
        end
        N_SQ: begin
          state <= N_SUM;
        end
        N_SUM: begin
          state <= N_SQRT;
        end
        N_SQRT: begin
          if (scnt == 5'(LW - 1)) begin
            state <= N_DINIT;
          end
        end
        N_DINIT: begin
          state <= N_DIV;
        end
        N_DIV: begin
          if (dcnt == '1) begin
            state <= N_STORE;
          end
        end
        N_STORE: begin
          state <= (k == 2'd2) ? N_OUT : N_DINIT;
        end
        N_OUT: begin
          state <= N_IDLE;
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      N_IDLE: begin
        if (go) begin
          sgn   <= {az[AW-1], ay[AW-1], ax[AW-1]};
          m0    <= ax[AW-1] ? -ax : ax;
          m1    <= ay[AW-1] ? -ay : ay;
          m2    <= az[AW-1] ? -az : az;
          nzero <= acc == '0;
          nx    <= '0;
          ny    <= '0;
          nz    <= '0;
        end
      end
      N_MAX: begin
        if (m0 >= m1 && m0 >= m2) begin
          mx <= m0;
        end else if (m1 >= m2) begin
          mx <= m1;
        end else begin
          mx <= m2;
        end
      end
      N_SHIFT: begin
        priority if (mx[AW-1:MW+7] != '0) begin
          mx <= mx >> 8; m0 <= m0 >> 8; m1 <= m1 >> 8; m2 <= m2 >> 8;
        end else if (mx[AW-1:MW] != '0) begin
          mx <= mx >> 1; m0 <= m0 >> 1; m1 <= m1 >> 1; m2 <= m2 >> 1;
        end else if (mx[AW-1:MW-9] == '0) begin
          mx <= mx << 8; m0 <= m0 << 8; m1 <= m1 << 8; m2 <= m2 << 8;
        end else if (!mx[MW-1]) begin
          mx <= mx << 1; m0 <= m0 << 1; m1 <= m1 << 1; m2 <= m2 << 1;
        end
      end
      N_SQ: begin
        sq0 <= m0[MW-1:0] * m0[MW-1:0];
        sq1 <= m1[MW-1:0] * m1[MW-1:0];
        sq2 <= m2[MW-1:0] * m2[MW-1:0];
      end
      N_SUM: begin
        rad  <= RW'(sq0) + RW'(sq1) + RW'(sq2);
        rem  <= '0;
        root <= '0;
        scnt <= '0;
        k    <= '0;
      end
      N_SQRT: begin
        if (rem_sh >= trial) begin
          rem  <= (LW + 2)'(rem_sh - trial);
          root <= {root[LW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[LW+1:0];
          root <= {root[LW-2:0], 1'b0};
        end
        rad  <= rad << 2;
        scnt <= scnt + 1'b1;
      end
      N_DINIT: begin
        drem <= (LW + 1)'(msel) + (LW + 1)'(root[LW-1:QW]);
        dlow <= root[QW-1:0];
        dcnt <= '0;
        quo  <= '0;
      end
      N_DIV: begin
        if (dsh >= dv) begin
          drem <= (LW + 1)'(dsh - dv);
          quo  <= {quo[QW-2:0], 1'b1};
        end else begin
          drem <= dsh[LW:0];
          quo  <= {quo[QW-2:0], 1'b0};
        end
        dlow <= dlow << 1;
        dcnt <= dcnt + 1'b1;
      end
      N_STORE: begin
        unique case (k)
          2'd0:    nx <= nval;
          2'd1:    ny <= nval;
          default: nz <= nval;
        endcase
        k <= k + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/vna_back.sv =====
// Back end: position and accumulator stores, triangle update and query sequencing.
module vna_back #(
  parameter int MAX_VERTICES  = vna_pkg::MAX_VERTICES_DEF,
  parameter int POSITION_BITS = vna_pkg::POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  vna_pkg::entry_t      head,
  output vna_pkg::back_stat_t  stat,
  output logic                 result_valid,
  output vna_pkg::result_t     result
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int PB  = POSITION_BITS;
  localparam int EW  = PB + 1;
  localparam int PW  = 2 * EW;
  localparam int FW  = PW + 1;
  localparam int CW  = vna_pkg::ACC_W;
  localparam int SW  = ((FW > CW) ? FW : CW) + 1;

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_LOAD  = 15'h0004,
    S_RA    = 15'h0008,
    S_RB    = 15'h0010,
    S_RC    = 15'h0020,
    S_EDGE  = 15'h0040,
    S_MUL   = 15'h0080,
    S_CROSS = 15'h0100,
    S_AR    = 15'h0200,
    S_AW    = 15'h0400,
    S_QRD   = 15'h0800,
    S_QGO   = 15'h1000,
    S_QWAIT = 15'h2000,
    S_QZ    = 15'h4000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  vna_pkg::entry_t        cur;
  logic [AW-1:0]          clr_cnt;
  logic [1:0]             k;

  logic [3*PB-1:0]        pos_mem [MAX_VERTICES];
  logic [3*PB-1:0]        pos_rd;
  logic [AW-1:0]          pos_raddr;
  logic                   pos_we;
  logic [3*CW-1:0]        acc_mem [MAX_VERTICES];
  logic [3*CW-1:0]        acc_rd;
  logic [AW-1:0]          acc_raddr;
  logic [AW-1:0]          acc_waddr;
  logic [3*CW-1:0]        acc_wdata;
  logic                   acc_we;

  logic [AW-1:0]          a_addr;
  logic [AW-1:0]          b_addr;
  logic [AW-1:0]          c_addr;
  logic [AW-1:0]          k_addr;
  logic [3*PB-1:0]        pos_word;

  logic [3*PB-1:0]        pa, pb;
  logic signed [EW-1:0]   e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PW-1:0]   p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [FW-1:0]   fx, fy, fz;

  logic                   norm_go;
  vna_pkg::norm_stat_t    nstat;
  logic signed [vna_pkg::NRM_W-1:0] nx, ny, nz;
  logic                   nzero;

  function automatic logic [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                            input logic signed [FW-1:0] b);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s[SW-1:CW-1] == {(SW - CW + 1){s[SW-1]}}) begin
      return s[CW-1:0];
    end
    return s[SW-1] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
  endfunction

  assign a_addr   = AW'(cur.ia);
  assign b_addr   = AW'(cur.ib);
  assign c_addr   = AW'(cur.ic);
  assign pos_word = {PB'(cur.pz), PB'(cur.py), PB'(cur.px)};

  assign stat.pop      = (state == S_IDLE) & head_valid;
  assign stat.clearing = state == S_CLEAR;
  assign norm_go       = state == S_QGO;

  always_comb begin
    unique case (k)
      2'd0:    k_addr = a_addr;
      2'd1:    k_addr = b_addr;
      default: k_addr = c_addr;
    endcase
  end

  always_comb begin
    pos_we    = 1'b0;
    pos_raddr = c_addr;
    acc_we    = 1'b0;
    acc_waddr = k_addr;
    acc_wdata = '0;
    acc_raddr = k_addr;
    unique case (state)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_cnt;
      end
      S_LOAD: begin
        pos_we    = 1'b1;
        acc_we    = 1'b1;
        acc_waddr = a_addr;
      end
      S_RA: pos_raddr = a_addr;
      S_RB: pos_raddr = b_addr;
      S_AW: begin
        acc_we    = 1'b1;
        acc_wdata = {sat_add(acc_rd[3*CW-1:2*CW], fz),
                     sat_add(acc_rd[2*CW-1:CW], fy),
                     sat_add(acc_rd[CW-1:0], fx)};
      end
      S_QRD: acc_raddr = a_addr;
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == AW'(MAX_VERTICES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (head_valid) begin
          unique case (head.op)
            vna_pkg::OP_LOAD:  state_next = S_LOAD;
            vna_pkg::OP_TRI:   state_next = S_RA;
            vna_pkg::OP_QUERY: state_next = S_QRD;
            default:           state_next = S_QZ;
          endcase
        end
      end
      S_LOAD:  state_next = S_IDLE;
      S_RA:    state_next = S_RB;
      S_RB:    state_next = S_RC;
      S_RC:    state_next = S_EDGE;
      S_EDGE:  state_next = S_MUL;
      S_MUL:   state_next = S_CROSS;
      S_CROSS: state_next = S_AR;
      S_AR:    state_next = S_AW;
      S_AW:    state_next = (k == 2'd2) ? S_IDLE : S_AR;
      S_QRD:   state_next = S_QGO;
      S_QGO:   state_next = S_QWAIT;
      S_QWAIT: if (nstat.done) state_next = S_IDLE;
      S_QZ:    state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= ((state == S_QWAIT) & nstat.done) | (state == S_QZ);
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[a_addr] <= pos_word;
    end
    pos_rd <= pos_mem[pos_raddr];
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rd <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (stat.pop) begin
      cur <= head;
    end
    unique case (state)
      S_RB: pa <= pos_rd;
      S_RC: pb <= pos_rd;
      S_EDGE: begin
        e1x <= EW'(signed'(pb[PB-1:0]))        - EW'(signed'(pa[PB-1:0]));
        e1y <= EW'(signed'(pb[2*PB-1:PB]))     - EW'(signed'(pa[2*PB-1:PB]));
        e1z <= EW'(signed'(pb[3*PB-1:2*PB]))   - EW'(signed'(pa[3*PB-1:2*PB]));
        e2x <= EW'(signed'(pos_rd[PB-1:0]))      - EW'(signed'(pa[PB-1:0]));
        e2y <= EW'(signed'(pos_rd[2*PB-1:PB]))   - EW'(signed'(pa[2*PB-1:PB]));
        e2z <= EW'(signed'(pos_rd[3*PB-1:2*PB])) - EW'(signed'(pa[3*PB-1:2*PB]));
      end
      S_MUL: begin
        p_yz <= e1y * e2z;
        p_zy <= e1z * e2y;
        p_zx <= e1z * e2x;
        p_xz <= e1x * e2z;
        p_xy <= e1x * e2y;
        p_yx <= e1y * e2x;
      end
      S_CROSS: begin
        fx <= FW'(p_yz) - FW'(p_zy);
        fy <= FW'(p_zx) - FW'(p_xz);
        fz <= FW'(p_xy) - FW'(p_yx);
        k  <= '0;
      end
      S_AW: k <= k + 1'b1;
      S_QWAIT: begin
        if (nstat.done) begin
          result.queried_index <= cur.ia;
          result.normal_x      <= nx;
          result.normal_y      <= ny;
          result.normal_z      <= nz;
          result.zero_normal   <= nzero;
        end
      end
      S_QZ: begin
        result.queried_index <= cur.ia;
        result.normal_x      <= '0;
        result.normal_y      <= '0;
        result.normal_z      <= '0;
        result.zero_normal   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .go    (norm_go),
    .acc   (acc_rd),
    .nstat (nstat),
    .nx    (nx),
    .ny    (ny),
    .nz    (nz),
    .nzero (nzero)
  );

`ifndef NO_ASSERTIONS
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back-to-back result strobes");
  a_norm_free: assert property (@(posedge clk) disable iff (rst)
    norm_go |-> nstat.idle)
    else $error("normalizer started while busy");
`endif

endmodule

// ===== src/vertex_normal_accumulator.sv =====
// Top level of the area-weighted vertex normal accumulator.
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. cmd selects load (store position, clear accumulator),
//   triangle (add the cross product of its edges to all three corners) or
//   query (report the unit normal of one vertex).
//   Result channel: each query yields one transaction on result, marked by a
//   one-cycle result_valid strobe; the receiver cannot stall it.
//   Configuration: cfg_we writes vertex_count; write it only while idle.
// Operation:
//   A two-entry queue separates the command front end from the executing back
//   end, so commands are taken while earlier ones still run; busy rises when
//   the queue is full. In the back end a triangle reads three positions, forms
//   the cross product and does three accumulator read-modify-writes over one
//   memory port; a query runs the 31-step square root and three 16-step
//   divisions in the normalizer, skipped on a zero accumulator, and its result
//   strobe is registered and follows the normalizer's finish in the next cycle.
// Reset:
//   Reset runs a clearing pass over all MAX_VERTICES accumulator entries;
//   busy stays high until it ends. Position store is not cleared.
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES  = vna_pkg::MAX_VERTICES_DEF,
  parameter int POSITION_BITS = vna_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  vna_pkg::item_t            item,
  output logic                      result_valid,
  output vna_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [vna_pkg::CNT_W-1:0] cfg_wdata
);

  vna_pkg::back_stat_t stat;
  vna_pkg::entry_t     head;
  logic                head_valid;

  vna_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .stat       (stat),
    .head_valid (head_valid),
    .head       (head)
  );

  vna_back #(
    .MAX_VERTICES  (MAX_VERTICES),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
